// ===== src/afns_pkg.sv =====
// ----------------------------------------------------------------------------
// afns_pkg
// Shared widths, register indexes and types for the aspect-fit scaler.
// ----------------------------------------------------------------------------
package afns_pkg;

  localparam int unsigned DimW    = 13;  // source, maximum and drawn sizes
  localparam int unsigned CoordW  = 12;  // canvas and source coordinates
  localparam int unsigned IdxW    = 24;  // linear source pixel index
  localparam int unsigned RemW    = 2 * DimW;  // dividend and partial remainder
  localparam int unsigned QuotW   = DimW;      // quotient bits, one per cell
  localparam int unsigned CfgIdxW = 4;

  // register indexes on the write port
  localparam logic [CfgIdxW-1:0] RegSrcWidth     = 4'd0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight    = 4'd1;
  localparam logic [CfgIdxW-1:0] RegSourceValid  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegOriginX      = 4'd3;
  localparam logic [CfgIdxW-1:0] RegOriginY      = 4'd4;
  localparam logic [CfgIdxW-1:0] RegMaxWidth     = 4'd5;
  localparam logic [CfgIdxW-1:0] RegMaxHeight    = 4'd6;
  localparam logic [CfgIdxW-1:0] RegAllowUpscale = 4'd7;

  // saturated configuration seen by the size unit
  typedef struct packed {
    logic [DimW-1:0] src_w;
    logic [DimW-1:0] src_h;
    logic [DimW-1:0] max_w;
    logic [DimW-1:0] max_h;
    logic            src_vld;
    logic            upscale;
  } size_cfg_t;

  // drawn size and status from the size unit
  typedef struct packed {
    logic            busy;
    logic [DimW-1:0] draw_w;
    logic [DimW-1:0] draw_h;
  } size_stat_t;

  // payload handed from cell to cell in the divider chain
  typedef struct packed {
    logic             cov;
    logic [RemW-1:0]  rem_x;
    logic [RemW-1:0]  rem_y;
    logic [QuotW-1:0] quo_x;
    logic [QuotW-1:0] quo_y;
  } div_data_t;

  typedef struct packed {
    logic      vld;
    div_data_t data;
  } cell_t;

  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] lim);
    sat_dim = (v > lim) ? lim : v;
  endfunction

endpackage

// ===== src/afns_div_cell.sv =====
// ----------------------------------------------------------------------------
// afns_div_cell
// One cell of the coordinate divider chain: resolves one quotient bit of the
// x and y divisions and hands the partial remainders to the next cell.
// ----------------------------------------------------------------------------
module afns_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [afns_pkg::DimW-1:0]   draw_w_i,
  input  logic [afns_pkg::DimW-1:0]   draw_h_i,
  input  afns_pkg::cell_t             cell_i,
  output afns_pkg::cell_t             cell_o
);

  logic                        vld_q;
  afns_pkg::div_data_t         data_q, data_d;
  logic [afns_pkg::RemW-1:0]   dsh_x, dsh_y;
  logic                        ge_x, ge_y;

  always_comb begin
    dsh_x  = afns_pkg::RemW'(draw_w_i) << SHIFT;
    dsh_y  = afns_pkg::RemW'(draw_h_i) << SHIFT;
    ge_x   = cell_i.data.rem_x >= dsh_x;
    ge_y   = cell_i.data.rem_y >= dsh_y;
    data_d = cell_i.data;
    if (ge_x) begin
      data_d.rem_x = cell_i.data.rem_x - dsh_x;
    end
    if (ge_y) begin
      data_d.rem_y = cell_i.data.rem_y - dsh_y;
    end
    data_d.quo_x[SHIFT] = ge_x;
    data_d.quo_y[SHIFT] = ge_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o = '{vld: vld_q, data: data_q};

endmodule

// ===== src/afns_size_unit.sv =====
// ----------------------------------------------------------------------------
// afns_size_unit
// Works out the drawn width and height after each register write: cross
// products, ratio compare, then a bit-serial divide for the scaled side unless a special case settles it.
// ----------------------------------------------------------------------------
module afns_size_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  kick_i,
  input  afns_pkg::size_cfg_t   cfg_i,
  output afns_pkg::size_stat_t  stat_o
);

  localparam int unsigned DimW = afns_pkg::DimW;
  localparam int unsigned RemW = afns_pkg::RemW;
  localparam int unsigned CntW = $clog2(DimW);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [DimW-1:0]  draw_w_q, draw_w_d, draw_h_q, draw_h_d;
  logic [DimW-1:0]  w_q, w_d, h_q, h_d;
  logic             none_q, none_d, div_q, div_d, to_h_q, to_h_d;
  logic [RemW-1:0]  pa_q, pa_d, pb_q, pb_d;
  logic [DimW-1:0]  den_q, den_d, rem_q, rem_d, num_q, num_d, quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DimW:0]    trial;
  logic [DimW-1:0]  w_res, h_res;

  always_comb begin
    state_d  = state_q;
    draw_w_d = draw_w_q;
    draw_h_d = draw_h_q;
    w_d      = w_q;
    h_d      = h_q;
    none_d   = none_q;
    div_d    = div_q;
    to_h_d   = to_h_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    den_d    = den_q;
    rem_d    = rem_q;
    num_d    = num_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    trial    = {rem_q, num_q[DimW-1]};
    w_res    = (div_q && !to_h_q) ? quo_q : w_q;
    h_res    = (div_q && to_h_q) ? quo_q : h_q;

    unique case (state_q)
      StIdle: begin
      end
      StMul: begin
        pa_d   = cfg_i.max_w * cfg_i.src_h;
        pb_d   = cfg_i.max_h * cfg_i.src_w;
        none_d = 1'b0;
        div_d  = 1'b0;
        state_d = StFin;
        if (!cfg_i.src_vld || cfg_i.src_w == '0 || cfg_i.src_h == '0) begin
          none_d = 1'b1;
          w_d    = '0;
          h_d    = '0;
        end else if (cfg_i.max_w == '0 || cfg_i.max_h == '0) begin
          w_d = DimW'(1);
          h_d = DimW'(1);
        end else if (!cfg_i.upscale && cfg_i.max_w >= cfg_i.src_w &&
                     cfg_i.max_h >= cfg_i.src_h) begin
          w_d = cfg_i.src_w;
          h_d = cfg_i.src_h;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        div_d = 1'b1;
        cnt_d = CntW'(DimW - 1);
        quo_d = '0;
        if (pa_q <= pb_q) begin
          // width ratio is the smaller or equal: height = sh * mw / sw
          w_d    = cfg_i.max_w;
          to_h_d = 1'b1;
          den_d  = cfg_i.src_w;
          rem_d  = pa_q[RemW-1:DimW];
          num_d  = pa_q[DimW-1:0];
        end else begin
          h_d    = cfg_i.max_h;
          to_h_d = 1'b0;
          den_d  = cfg_i.src_h;
          rem_d  = pb_q[RemW-1:DimW];
          num_d  = pb_q[DimW-1:0];
        end
        state_d = StDiv;
      end
      StDiv: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = DimW'(trial - {1'b0, den_q});
          quo_d = {quo_q[DimW-2:0], 1'b1};
        end else begin
          rem_d = trial[DimW-1:0];
          quo_d = {quo_q[DimW-2:0], 1'b0};
        end
        num_d = {num_q[DimW-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = StFin;
        end
      end
      StFin: begin
        // a valid source always draws at least one pixel each way
        draw_w_d = (!none_q && w_res == '0) ? DimW'(1) : w_res;
        draw_h_d = (!none_q && h_res == '0) ? DimW'(1) : h_res;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // restart on any register write
    if (kick_i) begin
      state_d = StMul;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      draw_w_q <= '0;
      draw_h_q <= '0;
    end else begin
      state_q  <= state_d;
      draw_w_q <= draw_w_d;
      draw_h_q <= draw_h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    none_q <= none_d;
    div_q  <= div_d;
    to_h_q <= to_h_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
  end

  assign stat_o = '{busy: (state_q != StIdle), draw_w: draw_w_q, draw_h: draw_h_q};

endmodule

// ===== src/aspect_fit_nearest_scaler.sv =====
// ----------------------------------------------------------------------------
// aspect_fit_nearest_scaler
// Maps a canvas pixel to the source pixel an aspect-fit, top-left anchored
// nearest-neighbor scaler copies there.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  config    cfg_we_i              cfg_idx_i, cfg_data_i
//  pixel in  start_i, busy_o       canvas_x_i, canvas_y_i
//  result    done_o (one cycle)    covered_o, source_x_o, source_y_o,
//                                  source_index_o
//
//  One item per cycle while busy_o is low; each item passes the stage A and stage B registers,
//  the divider chain of 13 cells, one quotient bit each, and the stage C and D registers.
//  After each register write busy_o stays high while the size unit recomputes the drawn
//  size; the serial divide, where it is needed, makes that update the longer one.
//  Reset clears the pipeline valid bits and sets the drawn size to 0x0.
//  The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module aspect_fit_nearest_scaler #(
  parameter int unsigned MAX_DIM       = 4096,
  parameter int unsigned CANVAS_WIDTH  = 1920,
  parameter int unsigned CANVAS_HEIGHT = 1080
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [afns_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [afns_pkg::DimW-1:0]       cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [afns_pkg::CoordW-1:0]     canvas_x_i,
  input  logic [afns_pkg::CoordW-1:0]     canvas_y_i,
  output logic                            done_o,
  output logic                            covered_o,
  output logic [afns_pkg::CoordW-1:0]     source_x_o,
  output logic [afns_pkg::CoordW-1:0]     source_y_o,
  output logic [afns_pkg::IdxW-1:0]       source_index_o
);

  localparam int unsigned DimW   = afns_pkg::DimW;
  localparam int unsigned CoordW = afns_pkg::CoordW;
  localparam int unsigned RemW   = afns_pkg::RemW;
  localparam int unsigned QuotW  = afns_pkg::QuotW;
  localparam int unsigned IdxW   = afns_pkg::IdxW;
  localparam int unsigned DimMax = (1 << DimW) - 1;
  localparam logic [DimW-1:0] SatLim =
      (MAX_DIM > DimMax) ? DimW'(DimMax) : DimW'(MAX_DIM);
  localparam logic [DimW-1:0] CanvasW = DimW'(CANVAS_WIDTH);
  localparam logic [DimW-1:0] CanvasH = DimW'(CANVAS_HEIGHT);
  localparam int unsigned Latency = QuotW + 4;

  // configuration registers
  logic [DimW-1:0]   src_w_q, src_h_q, max_w_q, max_h_q;
  logic [CoordW-1:0] org_x_q, org_y_q;
  logic              src_vld_q, upscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= '0;
      src_h_q   <= '0;
      src_vld_q <= 1'b0;
      org_x_q   <= '0;
      org_y_q   <= '0;
      max_w_q   <= '0;
      max_h_q   <= '0;
      upscale_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afns_pkg::RegSrcWidth:     src_w_q   <= cfg_data_i;
        afns_pkg::RegSrcHeight:    src_h_q   <= cfg_data_i;
        afns_pkg::RegSourceValid:  src_vld_q <= cfg_data_i[0];
        afns_pkg::RegOriginX:      org_x_q   <= cfg_data_i[CoordW-1:0];
        afns_pkg::RegOriginY:      org_y_q   <= cfg_data_i[CoordW-1:0];
        afns_pkg::RegMaxWidth:     max_w_q   <= cfg_data_i;
        afns_pkg::RegMaxHeight:    max_h_q   <= cfg_data_i;
        afns_pkg::RegAllowUpscale: upscale_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  afns_pkg::size_cfg_t  size_cfg;
  afns_pkg::size_stat_t size_stat;
  logic [DimW-1:0]      sw, sh;

  assign sw = afns_pkg::sat_dim(src_w_q, SatLim);
  assign sh = afns_pkg::sat_dim(src_h_q, SatLim);

  assign size_cfg = '{
    src_w:   sw,
    src_h:   sh,
    max_w:   afns_pkg::sat_dim(max_w_q, SatLim),
    max_h:   afns_pkg::sat_dim(max_h_q, SatLim),
    src_vld: src_vld_q,
    upscale: upscale_q
  };

  afns_size_unit u_size (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kick_i (cfg_we_i),
    .cfg_i  (size_cfg),
    .stat_o (size_stat)
  );

  assign busy_o = size_stat.busy;

  // stage A: coverage test and panel offset
  logic              accept;
  logic [CoordW-1:0] dx, dy;
  logic              cov;
  logic              a_vld_q, a_cov_q;
  logic [CoordW-1:0] a_dx_q, a_dy_q;

  assign accept = start_i && !busy_o;
  assign dx     = canvas_x_i - org_x_q;
  assign dy     = canvas_y_i - org_y_q;
  assign cov    = (size_stat.draw_w != '0) && (size_stat.draw_h != '0) &&
                  ({1'b0, canvas_x_i} < CanvasW) && ({1'b0, canvas_y_i} < CanvasH) &&
                  (canvas_x_i >= org_x_q) && (canvas_y_i >= org_y_q) &&
                  ({1'b0, dx} < size_stat.draw_w) && ({1'b0, dy} < size_stat.draw_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_cov_q <= cov;
    // zero the offsets of uncovered pixels so the chain sees clean operands
    a_dx_q  <= cov ? dx : '0;
    a_dy_q  <= cov ? dy : '0;
  end

  // stage B: dividends d * src, then the cell chain
  afns_pkg::cell_t  chain [QuotW+1];
  logic [RemW-1:0]  prod_x, prod_y;
  logic             b_vld_q;
  afns_pkg::div_data_t b_data_q;

  assign prod_x = {1'b0, a_dx_q} * sw;
  assign prod_y = {1'b0, a_dy_q} * sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_data_q <= '{cov: a_cov_q, rem_x: prod_x, rem_y: prod_y, quo_x: '0, quo_y: '0};
  end

  assign chain[0] = '{vld: b_vld_q, data: b_data_q};

  for (genvar g = 0; g < QuotW; g++) begin : g_cell
    afns_div_cell #(
      .SHIFT (QuotW - 1 - g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .draw_w_i (size_stat.draw_w),
      .draw_h_i (size_stat.draw_h),
      .cell_i   (chain[g]),
      .cell_o   (chain[g+1])
    );
  end

  // stage C: clamp to the last source pixel, row offset product
  afns_pkg::cell_t   tail;
  logic [DimW-1:0]   sw_m1, sh_m1, sx, sy;
  logic [RemW-1:0]   row_prod;
  logic              c_vld_q, c_cov_q;
  logic [DimW-1:0]   c_sx_q, c_sy_q;
  logic [RemW-1:0]   c_prod_q;

  assign tail     = chain[QuotW];
  assign sw_m1    = sw - DimW'(1);
  assign sh_m1    = sh - DimW'(1);
  assign sx       = (tail.data.quo_x > sw_m1) ? sw_m1 : tail.data.quo_x;
  assign sy       = (tail.data.quo_y > sh_m1) ? sh_m1 : tail.data.quo_y;
  assign row_prod = sy * sw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= tail.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c_cov_q  <= tail.data.cov;
    c_sx_q   <= sx;
    c_sy_q   <= sy;
    c_prod_q <= row_prod;
  end

  // stage D: result register, fields forced to zero when not covered
  logic              done_q, covered_q;
  logic [CoordW-1:0] src_x_q, src_y_q;
  logic [IdxW-1:0]   src_idx_q;
  logic [RemW-1:0]   idx_sum;

  assign idx_sum = c_prod_q + RemW'(c_sx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    covered_q <= c_cov_q;
    src_x_q   <= c_cov_q ? c_sx_q[CoordW-1:0] : '0;
    src_y_q   <= c_cov_q ? c_sy_q[CoordW-1:0] : '0;
    src_idx_q <= c_cov_q ? idx_sum[IdxW-1:0] : '0;
  end

  assign done_o         = done_q;
  assign covered_o      = covered_q;
  assign source_x_o     = src_x_q;
  assign source_y_o     = src_y_q;
  assign source_index_o = src_idx_q;

`ifndef SYNTHESIS
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without a matching item");

  a_uncov_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !covered_o) |->
      (source_x_o == '0 && source_y_o == '0 && source_index_o == '0))
    else $error("uncovered result carries nonzero source fields");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("register write did not start a size update");
`endif

endmodule
